/* rtl/core/jte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jte_pkg
// Shared types and constants of the joint target extrapolator: per-joint
// memory entry layout, the preview item handed to the velocity pipeline and
// register codes.
// ----------------------------------------------------------------------------
package jte_pkg;

	// field widths
	localparam int JI_W   = 5;
	localparam int DATA_W = 32;
	localparam int DB_W   = 31;

	// configuration register codes (word index on the register port)
	localparam int CFG_ADDR_W = 4;
	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_INV  = 2'd1;
	localparam logic [1:0] REG_DB   = 2'd2;

	// register reset values
	localparam logic [DATA_W-1:0] INV_RESET = 32'd65536000;

	// request codes
	localparam logic REQ_PREVIEW = 1'b0;
	localparam logic REQ_COMMIT  = 1'b1;

	// mode codes
	localparam logic MODE_PREDICT = 1'b0;
	localparam logic MODE_PASS    = 1'b1;

	// frame count saturates here
	localparam logic [1:0] FRAMES_MAX = 2'd2;

	// one memory word per joint
	typedef struct packed {
		logic signed [DATA_W-1:0] older;
		logic signed [DATA_W-1:0] last;
		logic signed [DATA_W-1:0] vel;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// what travels with a preview through the velocity pipeline
	typedef struct packed {
		logic [JI_W-1:0]          joint;
		logic                     startup;
		logic                     use_pred;
		logic signed [DATA_W-1:0] pos;
		logic signed [DATA_W-1:0] alt_vel;
		logic signed [DATA_W-1:0] pv;
	} side_t;

	// preview leaving the memory stage: p - p1, p2 - p1 and p2
	typedef struct packed {
		side_t                  side;
		logic signed [DATA_W:0] e;
		logic signed [DATA_W:0] f;
		logic signed [DATA_W-1:0] p2;
	} pred_in_t;

endpackage
`default_nettype wire

/* rtl/core/jte_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jte_ram
// Generic single-write, single-read synchronous RAM with registered read
// data. A read of the address being written returns the old word.
// ----------------------------------------------------------------------------
module jte_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/jte_entry_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jte_entry_stage
// Per-joint memory with read-modify-write. Reads the joint entry on accept,
// merges the last write by forwarding, writes commits back and forms the
// position differences of a preview.
// ----------------------------------------------------------------------------
module jte_entry_stage
	import jte_pkg::*;
#(
	parameter int JOINTS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     adv,
	input  wire logic                     in_valid,
	input  wire logic                     req_type,
	input  wire logic [JI_W-1:0]          joint_index,
	input  wire logic signed [DATA_W-1:0] raw_position,
	input  wire logic signed [DATA_W-1:0] sample_velocity,
	input  wire logic signed [DATA_W-1:0] committed_velocity,
	input  wire logic                     frame_end,
	input  wire logic                     predict_mode,
	output logic                          valid_s2,
	output pred_in_t                      item_s2
);

	localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam logic [8:0] JOINTS_N = 9'(JOINTS);

	// input address and range check
	logic [JI_W+AW-1:0] jext;
	logic [AW-1:0]      in_addr;
	logic               in_jok;
	logic               accept;

	assign jext    = {{AW{1'b0}}, joint_index};
	assign in_addr = jext[AW-1:0];
	assign in_jok  = ({4'b0, joint_index} < JOINTS_N);
	assign accept  = in_valid && adv;

	// stage 1 registers
	logic                     valid_s1;
	logic                     req_s1;
	logic [JI_W-1:0]          joint_s1;
	logic [AW-1:0]            addr_s1;
	logic                     jok_s1;
	logic signed [DATA_W-1:0] pos_s1;
	logic signed [DATA_W-1:0] rv_s1;
	logic signed [DATA_W-1:0] cv_s1;
	logic                     fend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1   <= req_type;
			joint_s1 <= joint_index;
			addr_s1  <= in_addr;
			jok_s1   <= in_jok;
			pos_s1   <= raw_position;
			rv_s1    <= sample_velocity;
			cv_s1    <= committed_velocity;
			fend_s1  <= frame_end;
		end
	end

	// joint memory
	logic               wr_en;
	entry_t             wr_data;
	logic [ENTRY_W-1:0] rdata;

	jte_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (JOINTS),
		.ADDR_W(AW)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(wr_data),
		.re   (accept),
		.raddr(in_addr),
		.rdata(rdata)
	);

	// forwarding of the previous write, velocity valid bits, frame count
	logic                 wr_valid_q;
	logic [AW-1:0]        wr_addr_q;
	entry_t               wr_data_q;
	logic [JOINTS-1:0]    vel_ok_q;
	logic [1:0]           fc_q;

	entry_t                   ent;
	logic                     fwd_hit;
	logic                     vel_ok;
	logic signed [DATA_W-1:0] p1;
	logic signed [DATA_W-1:0] p2;
	logic signed [DATA_W-1:0] pv;
	logic                     fc_step;

	always_comb begin
		fwd_hit = wr_valid_q && (wr_addr_q == addr_s1);
		ent     = fwd_hit ? wr_data_q : entry_t'(rdata);
		vel_ok  = vel_ok_q[addr_s1];
		p1      = jok_s1 ? ent.last : '0;
		p2      = jok_s1 ? ent.older : '0;
		pv      = (jok_s1 && vel_ok) ? ent.vel : '0;
	end

	// commit write back
	always_comb begin
		wr_en         = adv && valid_s1 && (req_s1 == REQ_COMMIT) && jok_s1;
		wr_data.older = (fc_q != 2'd0) ? ent.last : ent.older;
		wr_data.last  = pos_s1;
		wr_data.vel   = cv_s1;
		fc_step       = adv && valid_s1 && (req_s1 == REQ_COMMIT) && fend_s1
			&& (fc_q != FRAMES_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
			vel_ok_q   <= '0;
			fc_q       <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_valid_q        <= 1'b1;
				vel_ok_q[addr_s1] <= 1'b1;
			end
			if (fc_step) begin
				fc_q <= fc_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= wr_data;
		end
	end

	// preview item for the velocity pipeline
	pred_in_t nxt;

	always_comb begin
		nxt.side.joint    = joint_s1;
		nxt.side.pos      = pos_s1;
		nxt.side.pv       = pv;
		nxt.side.startup  = 1'b0;
		nxt.side.use_pred = 1'b0;
		nxt.side.alt_vel  = '0;
		if (predict_mode == MODE_PASS) begin
			nxt.side.alt_vel = rv_s1;
		end else if (fc_q != FRAMES_MAX) begin
			nxt.side.startup = 1'b1;
		end else begin
			nxt.side.use_pred = 1'b1;
		end
		nxt.e  = (DATA_W+1)'(pos_s1) - (DATA_W+1)'(p1);
		nxt.f  = (DATA_W+1)'(p2) - (DATA_W+1)'(p1);
		nxt.p2 = p2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && (req_s1 == REQ_PREVIEW);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= nxt;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/jte_vel_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jte_vel_pipe
// Prediction datapath: extrapolated position, velocity difference scaled
// by the reciprocal sample period with rounding, deadband hold, saturation
// and the output register.
// ----------------------------------------------------------------------------
module jte_vel_pipe
	import jte_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     valid_s2,
	input  wire pred_in_t                 item_s2,
	input  wire logic [DATA_W-1:0]        inv_period,
	input  wire logic [DB_W-1:0]          deadband,
	input  wire logic                     out_stall,
	output logic                          adv,
	output logic                          out_valid,
	output logic [JI_W-1:0]               out_joint,
	output logic signed [DATA_W-1:0]      target_position,
	output logic signed [DATA_W-1:0]      target_velocity,
	output logic                          startup
);

	localparam int POS_W  = 36;
	localparam int MAG_W  = 36;
	localparam int HALF_W = 16;
	localparam int PROD_W = MAG_W + HALF_W;
	localparam int R_W    = PROD_W + 1;
	localparam int V_W    = R_W + 1;
	localparam int DIFF_W = V_W + 1;
	localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1 << (HALF_W - 1));

	// whole pipeline moves unless a finished result is held
	assign adv = !(out_valid && out_stall);

	// stage 3: extrapolated position and velocity difference
	logic                    valid_s3;
	side_t                   side_s3;
	logic signed [POS_W-1:0] pos_s3;
	logic signed [POS_W-1:0] d_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= item_s2.side;
			pos_s3  <= POS_W'(item_s2.e) + (POS_W'(item_s2.e) <<< 1) + POS_W'(item_s2.p2);
			d_s3    <= (POS_W'(item_s2.e) <<< 1) + POS_W'(item_s2.f);
		end
	end

	// stage 4: position saturation, magnitude and sign of the difference
	logic             valid_s4;
	side_t            side_s4;
	logic             neg_s4;
	logic [MAG_W-1:0] mag_s4;
	logic             pos_ovf;

	assign pos_ovf = !((&pos_s3[POS_W-1:DATA_W-1]) || !(|pos_s3[POS_W-1:DATA_W-1]));

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side_s3;
			if (side_s3.use_pred) begin
				if (pos_ovf) begin
					side_s4.pos <= pos_s3[POS_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
						: {1'b0, {(DATA_W-1){1'b1}}};
				end else begin
					side_s4.pos <= pos_s3[DATA_W-1:0];
				end
			end
			neg_s4 <= d_s3[POS_W-1];
			mag_s4 <= d_s3[POS_W-1] ? MAG_W'(-d_s3) : MAG_W'(d_s3);
		end
	end

	// stage 5: two partial products over the period halves
	logic              valid_s5;
	side_t             side_s5;
	logic              neg_s5;
	logic [PROD_W-1:0] hi_s5;
	logic [PROD_W-1:0] lo_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_s4;
			neg_s5  <= neg_s4;
			hi_s5   <= {{HALF_W{1'b0}}, mag_s4} * {{MAG_W{1'b0}}, inv_period[DATA_W-1:HALF_W]};
			lo_s5   <= {{HALF_W{1'b0}}, mag_s4} * {{MAG_W{1'b0}}, inv_period[HALF_W-1:0]};
		end
	end

	// stage 6: rounded magnitude
	logic            valid_s6;
	side_t           side_s6;
	logic            neg_s6;
	logic [R_W-1:0]  r_s6;
	logic [PROD_W:0] lo_rnd;

	assign lo_rnd = (PROD_W+1)'(lo_s5) + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s6 <= side_s5;
			neg_s6  <= neg_s5;
			r_s6    <= R_W'(hi_s5) + R_W'(lo_rnd[PROD_W:HALF_W]);
		end
	end

	// stage 7: signed velocity
	logic                  valid_s7;
	side_t                 side_s7;
	logic signed [V_W-1:0] v_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s7 <= side_s6;
			v_s7    <= neg_s6 ? -$signed({1'b0, r_s6}) : $signed({1'b0, r_s6});
		end
	end

	// stage 8: distance from the last committed velocity
	logic                     valid_s8;
	side_t                    side_s8;
	logic signed [V_W-1:0]    v_s8;
	logic signed [DIFF_W-1:0] diff_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s8 <= side_s7;
			v_s8    <= v_s7;
			diff_s8 <= DIFF_W'(v_s7) - DIFF_W'(side_s7.pv);
		end
	end

	// valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			out_valid <= valid_s8;
		end
	end

	// deadband hold, velocity saturation and selection
	logic signed [DIFF_W-1:0] db_ext;
	logic                     in_band;
	logic                     v_ovf;
	logic signed [DATA_W-1:0] v_sat;
	logic signed [DATA_W-1:0] vel_sel;

	always_comb begin
		db_ext  = $signed({{(DIFF_W-DB_W){1'b0}}, deadband});
		in_band = (diff_s8 <= db_ext) && (diff_s8 >= -db_ext);
		v_ovf   = !((&v_s8[V_W-1:DATA_W-1]) || !(|v_s8[V_W-1:DATA_W-1]));
		if (v_ovf) begin
			v_sat = v_s8[V_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			v_sat = v_s8[DATA_W-1:0];
		end
		if (!side_s8.use_pred) begin
			vel_sel = side_s8.alt_vel;
		end else if (in_band) begin
			vel_sel = side_s8.pv;
		end else begin
			vel_sel = v_sat;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_joint       <= side_s8.joint;
			target_position <= side_s8.pos;
			target_velocity <= vel_sel;
			startup         <= side_s8.startup;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/joint_target_extrapolator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joint_target_extrapolator
// Per-joint quadratic extrapolation of position and velocity targets from
// the last two committed positions and the last committed velocity.
// ----------------------------------------------------------------------------
//  port group   direction  flow control     contents
//  in_*         in         in_valid/stall   request, joint, samples
//  out_*        out        out_valid/stall  joint, target position/velocity
//  p*           in/out     apb, pready=1    mode, period, deadband
//
// One item per cycle while no stalled result is held; out_valid of a preview
// rises after its transfer has passed the stage 1 memory read, the stage 2 merge
// register, stages s3 to s8 of the scaling multiplier pipeline and the output register.
// Commits give no result. A commit followed at once by an item
// of the same joint is served by forwarding of the last memory write.
// Reset clears only control state and the per-joint velocity valid bits;
// no memory clearing pass. A stalled result freezes the whole pipeline and
// raises in_stall in the same cycle.
// ----------------------------------------------------------------------------
module joint_target_extrapolator
	import jte_pkg::*;
#(
	parameter int JOINTS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// request channel
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     req_type,
	input  wire logic [JI_W-1:0]          joint_index,
	input  wire logic signed [DATA_W-1:0] raw_position,
	input  wire logic signed [DATA_W-1:0] sample_velocity,
	input  wire logic signed [DATA_W-1:0] committed_velocity,
	input  wire logic                     frame_end,
	// result channel
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [JI_W-1:0]               out_joint,
	output logic signed [DATA_W-1:0]      target_position,
	output logic signed [DATA_W-1:0]      target_velocity,
	output logic                          startup,
	// register port
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [CFG_ADDR_W-1:0]    paddr,
	input  wire logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready
);

	// configuration registers
	logic              mode_q;
	logic [DATA_W-1:0] inv_q;
	logic [DB_W-1:0]   db_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PREDICT;
			inv_q  <= INV_RESET;
			db_q   <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MODE: mode_q <= pwdata[0];
				REG_INV:  inv_q  <= pwdata;
				REG_DB:   db_q   <= pwdata[DB_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			REG_MODE: prdata = {{(DATA_W-1){1'b0}}, mode_q};
			REG_INV:  prdata = inv_q;
			REG_DB:   prdata = {{(DATA_W-DB_W){1'b0}}, db_q};
			default:  prdata = '0;
		endcase
	end

	// memory stage and prediction pipeline
	logic     adv;
	logic     valid_s2;
	pred_in_t item_s2;

	assign in_stall = !adv;

	jte_entry_stage #(
		.JOINTS(JOINTS)
	) u_entry (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (adv),
		.in_valid          (in_valid),
		.req_type          (req_type),
		.joint_index       (joint_index),
		.raw_position      (raw_position),
		.sample_velocity   (sample_velocity),
		.committed_velocity(committed_velocity),
		.frame_end         (frame_end),
		.predict_mode      (mode_q),
		.valid_s2          (valid_s2),
		.item_s2           (item_s2)
	);

	jte_vel_pipe u_vel (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s2       (valid_s2),
		.item_s2        (item_s2),
		.inv_period     (inv_q),
		.deadband       (db_q),
		.out_stall      (out_stall),
		.adv            (adv),
		.out_valid      (out_valid),
		.out_joint      (out_joint),
		.target_position(target_position),
		.target_velocity(target_velocity),
		.startup        (startup)
	);

endmodule
`default_nettype wire

/* tb/jte_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jte_checker
// Watches the request, result and register ports of the joint target
// extrapolator. It keeps its own copy of the per-joint position and velocity
// history and of the registers, forecasts one target per preview transfer and
// compares every result transfer with the oldest forecast still due.
// ----------------------------------------------------------------------------
module jte_checker
	import jte_pkg::*;
#(
	parameter int JOINTS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// request channel
	input  wire logic                     in_valid,
	input  wire logic                     in_stall,
	input  wire logic                     req_type,
	input  wire logic [JI_W-1:0]          joint_index,
	input  wire logic signed [DATA_W-1:0] raw_position,
	input  wire logic signed [DATA_W-1:0] sample_velocity,
	input  wire logic signed [DATA_W-1:0] committed_velocity,
	input  wire logic                     frame_end,
	// result channel
	input  wire logic                     out_valid,
	input  wire logic                     out_stall,
	input  wire logic [JI_W-1:0]          out_joint,
	input  wire logic signed [DATA_W-1:0] target_position,
	input  wire logic signed [DATA_W-1:0] target_velocity,
	input  wire logic                     startup,
	// register port
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [CFG_ADDR_W-1:0]    paddr,
	input  wire logic [DATA_W-1:0]        pwdata,
	input  wire logic [DATA_W-1:0]        prdata,
	input  wire logic                     pready,
	// status toward the testbench top
	output int                            errors,
	output int                            pending
);

	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint NEG_MIN = -64'sd2147483648;
	localparam int     REPORT_MAX = 10;

	// one expected preview result
	typedef struct packed {
		logic [JI_W-1:0]          joint;
		logic signed [DATA_W-1:0] pos;
		logic signed [DATA_W-1:0] vel;
		logic                     startup;
	} target_t;

	target_t targets_due[$];

	// shadow registers
	logic              mode;
	logic [DATA_W-1:0] inv_period;
	logic [DB_W-1:0]   deadband;

	// shadow per-joint history
	logic signed [DATA_W-1:0] last_pos  [JOINTS];
	logic signed [DATA_W-1:0] older_pos [JOINTS];
	logic signed [DATA_W-1:0] last_vel  [JOINTS];
	logic [1:0]               frames;

	// clamp to the signed 32-bit field range
	function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
		if (v > POS_MAX) return POS_MAX[DATA_W-1:0];
		if (v < NEG_MIN) return NEG_MIN[DATA_W-1:0];
		return v[DATA_W-1:0];
	endfunction

	// d times the Q16.16 rate, rounded to nearest with ties away from zero
	function automatic longint scale_rate(input longint d, input logic [DATA_W-1:0] inv);
		logic        neg;
		logic [63:0] mag;
		logic [63:0] r;
		neg = d < 0;
		mag = neg ? -d : d;
		r = mag * inv[31:16] + ((mag * inv[15:0] + 64'h8000) >> 16);
		return neg ? -longint'(r) : longint'(r);
	endfunction

	// target for one preview from the current history and registers
	function automatic target_t forecast(input logic [JI_W-1:0] j,
		input logic signed [DATA_W-1:0] p, input logic signed [DATA_W-1:0] rv);
		target_t t;
		longint  p1;
		longint  p2;
		longint  pv;
		longint  v;
		longint  gap;
		logic    ok;
		ok = j < JOINTS;
		t.joint = j;
		t.startup = 1'b0;
		if (mode == MODE_PASS) begin
			t.pos = p;
			t.vel = rv;
		end else if (frames < FRAMES_MAX) begin
			t.pos = p;
			t.vel = '0;
			t.startup = 1'b1;
		end else begin
			p1 = ok ? longint'(last_pos[j]) : 0;
			p2 = ok ? longint'(older_pos[j]) : 0;
			pv = ok ? longint'(last_vel[j]) : 0;
			t.pos = clamp32(3 * longint'(p) - 3 * p1 + p2);
			v = scale_rate(2 * longint'(p) - 3 * p1 + p2, inv_period);
			gap = v - pv;
			if (gap < 0) gap = -gap;
			// hold the committed velocity inside the deadband
			t.vel = clamp32((gap <= longint'(deadband)) ? pv : v);
		end
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		target_t           want;
		logic [DATA_W-1:0] reg_want;
		logic              reg_known;
		if (!arst_n) begin
			mode = MODE_PREDICT;
			inv_period = INV_RESET;
			deadband = '0;
			frames = '0;
			for (int i = 0; i < JOINTS; i++) begin
				last_pos[i] = '0;
				older_pos[i] = '0;
				last_vel[i] = '0;
			end
			targets_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			// result transfer against the oldest forecast
			if (out_valid && !out_stall) begin
				if (targets_due.size() == 0) begin
					if (errors < REPORT_MAX)
						$display("unexpected result: joint %0d pos %0d vel %0d startup %0b",
							out_joint, target_position, target_velocity, startup);
					errors++;
				end else begin
					want = targets_due.pop_front();
					if (want.joint !== out_joint || want.pos !== target_position ||
						want.vel !== target_velocity || want.startup !== startup) begin
						if (errors < REPORT_MAX)
							$display("mismatch: joint %0d/%0d pos %0d/%0d vel %0d/%0d startup %0b/%0b",
								want.joint, out_joint, want.pos, target_position,
								want.vel, target_velocity, want.startup, startup);
						errors++;
					end
				end
			end

			// request transfer: forecast a preview or update the history
			if (in_valid && !in_stall) begin
				if (req_type == REQ_PREVIEW) begin
					targets_due.insert(targets_due.size(),
						forecast(joint_index, raw_position, sample_velocity));
				end else begin
					if (joint_index < JOINTS) begin
						if (frames != 0) older_pos[joint_index] = last_pos[joint_index];
						last_pos[joint_index] = raw_position;
						last_vel[joint_index] = committed_velocity;
					end
					if (frame_end && frames < FRAMES_MAX) frames++;
				end
			end

			// register writes and read-back
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_MODE: mode = pwdata[0];
						REG_INV:  inv_period = pwdata;
						REG_DB:   deadband = pwdata[DB_W-1:0];
						default:  ;
					endcase
				end else begin
					reg_known = 1'b1;
					reg_want = '0;
					case (paddr[3:2])
						REG_MODE: reg_want = {{(DATA_W-1){1'b0}}, mode};
						REG_INV:  reg_want = inv_period;
						REG_DB:   reg_want = {1'b0, deadband};
						default:  reg_known = 1'b0;
					endcase
					if (reg_known && prdata !== reg_want) begin
						if (errors < REPORT_MAX)
							$display("register read at %0d: expected %0h got %0h",
								paddr, reg_want, prdata);
						errors++;
					end
				end
			end

			pending = targets_due.size();
		end
	end

endmodule

/* tb/tb_joint_target_extrapolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joint_target_extrapolator
// Drives the joint target extrapolator with a directed start-up sequence
// and with random commit and preview streams over several register settings
// and idle patterns, including one long receiver hold-off. The checker beside
// the block forecasts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_joint_target_extrapolator;
	import jte_pkg::*;

	localparam int JOINTS      = 32;
	localparam int LIMIT       = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 20;

	// register index that decodes to nothing
	localparam logic [1:0] REG_NONE = 2'd3;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic                     req_type;
	logic [JI_W-1:0]          joint_index;
	logic signed [DATA_W-1:0] raw_position;
	logic signed [DATA_W-1:0] sample_velocity;
	logic signed [DATA_W-1:0] committed_velocity;
	logic                     frame_end;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [JI_W-1:0]          out_joint;
	logic signed [DATA_W-1:0] target_position;
	logic signed [DATA_W-1:0] target_velocity;
	logic                     startup;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_W-1:0]    paddr;
	logic [DATA_W-1:0]        pwdata;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;

	int fail_count;
	int due_count;

	// idle control
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_id = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycles = 0;
	logic req_taken;

	// stimulus bookkeeping: what has been committed so far
	logic                     cur_mode;
	logic [DATA_W-1:0]        cur_inv;
	logic signed [DATA_W-1:0] gen_last     [JOINTS];
	logic signed [DATA_W-1:0] gen_older    [JOINTS];
	logic                     gen_last_ok  [JOINTS];
	logic                     gen_older_ok [JOINTS];
	int                       gen_frames;

	joint_target_extrapolator #(.JOINTS(JOINTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
		.joint_index(joint_index), .raw_position(raw_position),
		.sample_velocity(sample_velocity), .committed_velocity(committed_velocity),
		.frame_end(frame_end),
		.out_valid(out_valid), .out_stall(out_stall), .out_joint(out_joint),
		.target_position(target_position), .target_velocity(target_velocity),
		.startup(startup),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	jte_checker #(.JOINTS(JOINTS)) target_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
		.joint_index(joint_index), .raw_position(raw_position),
		.sample_velocity(sample_velocity), .committed_velocity(committed_velocity),
		.frame_end(frame_end),
		.out_valid(out_valid), .out_stall(out_stall), .out_joint(out_joint),
		.target_position(target_position), .target_velocity(target_velocity),
		.startup(startup),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.errors(fail_count), .pending(due_count)
	);

	always #5 clk = ~clk;

	// request transfer seen at the last rising edge
	always @(posedge clk) begin
		req_taken <= in_valid && !in_stall;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_id != hold_seen) begin
			hold_seen = hold_id;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
		end
	end

	// log-uniform magnitude with a random sign
	function automatic logic signed [DATA_W-1:0] noise();
		int unsigned w;
		logic [31:0] r;
		w = $urandom_range(31);
		r = $urandom & ((32'd1 << w) - 32'd1);
		return $urandom_range(1) ? -$signed(r) : $signed(r);
	endfunction

	task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic reg_read(input logic [1:0] idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic m, input logic [DATA_W-1:0] inv,
		input logic [DB_W-1:0] db);
		reg_write(REG_MODE, {{(DATA_W-1){1'b0}}, m});
		reg_write(REG_INV, inv);
		reg_write(REG_DB, {1'b0, db});
		reg_read(REG_MODE);
		reg_read(REG_INV);
		reg_read(REG_DB);
		cur_mode = m;
		cur_inv = inv;
	endtask

	// one request transfer, after a random idle gap
	task automatic send_item(input logic req, input logic [JI_W-1:0] j,
		input logic signed [DATA_W-1:0] p, input logic signed [DATA_W-1:0] rv,
		input logic signed [DATA_W-1:0] cv, input logic fe);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		joint_index <= j;
		raw_position <= p;
		sample_velocity <= rv;
		committed_velocity <= cv;
		frame_end <= fe;
		@(negedge clk);
		while (!req_taken) @(negedge clk);
		// mirror the commit so previews never read an unwritten store
		if (req == REQ_COMMIT) begin
			if (gen_frames > 0) begin
				gen_older[j] = gen_last[j];
				gen_older_ok[j] = gen_last_ok[j];
			end
			gen_last[j] = p;
			gen_last_ok[j] = 1'b1;
			if (fe && gen_frames < int'(FRAMES_MAX)) gen_frames++;
		end
	endtask

	// random item: mostly constant-rate trajectories with noise
	task automatic send_random(input int commit_pct);
		logic                     req;
		logic [JI_W-1:0]          j;
		logic signed [DATA_W-1:0] p;
		logic signed [DATA_W-1:0] rv;
		logic signed [DATA_W-1:0] cv;
		logic                     fe;
		longint                   rate;
		j = $urandom_range(1) ? JI_W'($urandom_range(3)) : JI_W'($urandom_range(JOINTS - 1));
		req = ($urandom_range(99) < commit_pct) ? REQ_COMMIT : REQ_PREVIEW;
		if (req == REQ_PREVIEW && cur_mode == MODE_PREDICT && gen_frames >= int'(FRAMES_MAX) &&
			!(gen_last_ok[j] && gen_older_ok[j]))
			req = REQ_COMMIT;
		rate = longint'(gen_last[j]) - longint'(gen_older[j]);
		case ($urandom_range(9))
			0: p = $urandom;
			1: p = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: p = DATA_W'(longint'(gen_last[j]) + rate + longint'(noise()));
		endcase
		rv = $urandom_range(1) ? noise() : $urandom;
		// committed velocity near the rate the next preview will see
		if ($urandom_range(9) < 6)
			cv = DATA_W'(((longint'(p) - longint'(gen_last[j])) * longint'(cur_inv)) >>> 16)
				+ noise();
		else
			cv = $urandom;
		fe = $urandom_range(4) == 0;
		send_item(req, j, p, rv, cv, fe);
	endtask

	// wait for every result, then let the pipeline run empty
	task automatic settle();
		in_valid <= 1'b0;
		while (due_count != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_phase(input int n, input int commit_pct, input int send_pct,
		input int recv_pct, input logic hold);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (hold) hold_id <= hold_id + 1;
		repeat (n) send_random(commit_pct);
		settle();
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_PREVIEW;
		joint_index = '0;
		raw_position = '0;
		sample_velocity = '0;
		committed_velocity = '0;
		frame_end = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_mode = MODE_PREDICT;
		cur_inv = INV_RESET;
		gen_frames = 0;
		for (int i = 0; i < JOINTS; i++) begin
			gen_last[i] = '0;
			gen_older[i] = '0;
			gen_last_ok[i] = 1'b0;
			gen_older_ok[i] = 1'b0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// start-up previews with reset registers, frame count building up
		send_item(REQ_PREVIEW, 5'd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 1'b0);
		send_item(REQ_PREVIEW, 5'd31, 32'sh80000000, 32'sh7FFFFFFF, 32'sh0, 1'b1);
		send_item(REQ_COMMIT, 5'd0, 32'sh10000, 32'sh0, 32'sh0, 1'b0);
		send_item(REQ_COMMIT, 5'd1, 32'sh0, 32'sh0, 32'sh7FFFFFFF, 1'b1);
		send_item(REQ_PREVIEW, 5'd0, 32'sh5, 32'sh1234, 32'sh0, 1'b0);
		send_item(REQ_COMMIT, 5'd0, 32'sh20000, 32'sh0, 32'sh800, 1'b0);
		send_item(REQ_COMMIT, 5'd1, 32'sh0, 32'sh0, 32'sh0, 1'b1);
		// first full prediction, then saturation with back-to-back commits
		send_item(REQ_PREVIEW, 5'd0, 32'sh30000, 32'sh0, 32'sh0, 1'b0);
		send_item(REQ_COMMIT, 5'd0, 32'sh7FFFFFFF, 32'sh0, 32'sh80000000, 1'b1);
		send_item(REQ_COMMIT, 5'd0, 32'sh80000000, 32'sh0, 32'sh7FFFFFFF, 1'b0);
		send_item(REQ_PREVIEW, 5'd0, 32'sh7FFFFFFF, 32'sh0, 32'sh0, 1'b0);
		send_item(REQ_PREVIEW, 5'd0, 32'sh80000000, 32'sh0, 32'sh0, 1'b0);
		send_item(REQ_COMMIT, 5'd1, 32'sh7FFFFFFF, 32'sh0, 32'sh0, 1'b0);
		send_item(REQ_PREVIEW, 5'd1, 32'sh80000000, 32'sh0, 32'sh0, 1'b0);
		settle();

		// pass-through of raw extremes
		configure(MODE_PASS, INV_RESET, '0);
		send_item(REQ_PREVIEW, 5'd31, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 1'b0);
		send_item(REQ_PREVIEW, 5'd5, 32'sh80000000, 32'sh7FFFFFFF, 32'sh0, 1'b0);
		settle();

		// zero rate gives zero velocity before the deadband
		configure(MODE_PREDICT, 32'd0, '0);
		send_item(REQ_PREVIEW, 5'd0, 32'sh10000, 32'sh0, 32'sh0, 1'b0);
		settle();

		// deadband edge: exactly on the band is held, just past it is not
		configure(MODE_PREDICT, 32'd65536, 31'h1000);
		send_item(REQ_COMMIT, 5'd2, 32'sh1, 32'sh0, 32'sh0, 1'b0);
		send_item(REQ_COMMIT, 5'd2, 32'sh0, 32'sh0, -32'sd3583, 1'b0);
		send_item(REQ_PREVIEW, 5'd2, 32'sh100, 32'sh0, 32'sh0, 1'b0);
		send_item(REQ_PREVIEW, 5'd2, 32'sh101, 32'sh0, 32'sh0, 1'b0);
		settle();

		// rounding of half steps away from zero; a write to no register
		configure(MODE_PREDICT, 32'h8000, '0);
		reg_write(REG_NONE, 32'hFFFFFFFF);
		send_item(REQ_PREVIEW, 5'd2, 32'sh0, 32'sh0, 32'sh0, 1'b0);
		send_item(REQ_PREVIEW, 5'd2, -32'sd1, 32'sh0, 32'sh0, 1'b0);
		settle();

		// random streams over register settings and idle patterns
		configure(MODE_PREDICT, INV_RESET, '0);
		run_phase(200, 50, 0, 0, 1'b0);
		configure(MODE_PREDICT, 32'd1, 31'h7FFFFFFF);
		run_phase(190, 40, 65, 0, 1'b0);
		configure(MODE_PASS, 32'hFFFFFFFF, DB_W'($urandom));
		run_phase(190, 40, 0, 65, 1'b0);
		configure(MODE_PREDICT, 32'hFFFFFFFF, DB_W'($urandom_range(0, 1 << 20)));
		run_phase(190, 40, 22, 22, 1'b0);
		// long receiver hold-off while previews keep coming
		configure(MODE_PREDICT, $urandom_range(1, 32'h00FFFFFF), DB_W'($urandom_range(0, 65535)));
		run_phase(200, 10, 0, 0, 1'b1);
		configure(MODE_PREDICT, 32'd65536, DB_W'($urandom));
		run_phase(190, 40, 65, 0, 1'b0);
		configure(MODE_PREDICT, $urandom, DB_W'($urandom_range(0, 1 << 16)));
		run_phase(190, 40, 0, 65, 1'b0);
		configure(MODE_PREDICT, 32'h8000, '0);
		run_phase(190, 40, 22, 22, 1'b0);

		if (fail_count == 0 && due_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/jte_pkg.sv
rtl/core/jte_ram.sv
rtl/core/jte_entry_stage.sv
rtl/core/jte_vel_pipe.sv
rtl/core/joint_target_extrapolator.sv
tb/jte_checker.sv
tb/tb_joint_target_extrapolator.sv
